// ===== src/zbps_pkg.sv =====
// Package for the z-buffer point splatting unit.
// Holds the item payload types, controller command and status types and register indexes.
// No dependencies.
`default_nettype none
package zbps_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int DEPTH_BITS_DEF = 24;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_GSD       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INVERSE_MODE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_IN_USE  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_IN_USE = 3'd5;

  localparam logic [31:0] INV_GSD_RESET = 32'd327680;
  localparam logic [9:0]  DIM_RESET     = 10'd512;

  // One half in Q.24, for round to nearest with ties upward.
  localparam logic [63:0] HALF_Q24 = 64'h0000_0000_0080_0000;

  localparam logic MODE_SPLAT = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [23:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [8:0]         read_col;
    logic [8:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic               written;
    logic               pix_valid;
    logic signed [23:0] pix_depth;
    logic [7:0]         pix_red;
    logic [7:0]         pix_green;
    logic [7:0]         pix_blue;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic mul_x;
    logic mul_y;
    logic map_y;
    logic rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mode;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/zbps_in_if.sv =====
// Input channel of the z-buffer point splatting unit: valid, ready and one input item.
// Depends on zbps_pkg.
`default_nettype none
interface zbps_in_if;
  logic               valid;
  logic               ready;
  zbps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/zbps_out_if.sv =====
// Result channel of the z-buffer point splatting unit: valid, ready and one result item.
// Depends on zbps_pkg.
`default_nettype none
interface zbps_out_if;
  logic                valid;
  logic                ready;
  zbps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/zbuffer_point_splat_ortho_unit.sv =====
// Top level of the z-buffer point splatting unit: controller plus datapath.
// Depends on zbps_pkg, zbps_in_if, zbps_out_if, zbps_ctrl and zbps_dp.
//
// The unit maps colored ground points onto an orthographic pixel grid and keeps,
// per pixel, the nearest (or with inverse_mode the farthest) depth and its color.
// After reset the unit first runs a clearing pass over all pixels of the valid
// map, one pixel per cycle; during it no item is accepted, while configuration
// writes are taken as usual. Items are handled one at a time. A splat item goes
// through capture, two passes through one shared 32x32 multiplier for the x and
// y products, the rounding and range check of the y pixel, the pixel store read
// and the depth test with write-back, held while the output register is full.
// A read item skips the multiplier and the y mapping. The next item is accepted
// as soon as the result sits in the output register, even if the sink has not
// taken it yet. Configuration must be written only while the unit is idle.
`default_nettype none
module zbuffer_point_splat_ortho_unit #(
  parameter int MAX_WIDTH  = zbps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbps_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = zbps_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [zbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [zbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  zbps_in_if.sink                                  in_ch,
  zbps_out_if.source                               out_ch
);
  zbps_pkg::cmd_t    cmd;
  zbps_pkg::status_t st;

  // The controller sequences one item at a time through the datapath.
  zbps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .cmd(cmd)
  );

  // The datapath owns the registers, the multiplier and the pixel stores.
  zbps_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .DEPTH_BITS(DEPTH_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(in_ch.data), .cmd(cmd), .st(st),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
`default_nettype wire

// ===== src/zbps_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module zbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/zbps_ctrl.sv =====
// Controller state machine of the z-buffer point splatting unit.
// Depends on zbps_pkg; drives the datapath by command and status structs.
`default_nettype none
module zbps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire zbps_pkg::status_t st,
  output zbps_pkg::cmd_t         cmd
);
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MX   = 3'd2;
  localparam logic [2:0] S_MY   = 3'd3;
  localparam logic [2:0] S_AY   = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_MX;
        end
      end
      S_MX: begin
        // A read item has its pixel settled at capture.
        if (st.mode == zbps_pkg::MODE_READ) begin
          state_next = S_RD;
        end else begin
          cmd.mul_x = 1'b1;
          state_next = S_MY;
        end
      end
      S_MY: begin
        cmd.mul_y = 1'b1;
        state_next = S_AY;
      end
      S_AY: begin
        cmd.map_y = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/zbps_dp.sv =====
// Datapath of the z-buffer point splatting unit: registers, shared multiplier,
// pixel mapping, pixel stores and result register. Depends on zbps_pkg and zbps_ram.
`default_nettype none
module zbps_dp #(
  parameter int MAX_WIDTH  = zbps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbps_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = zbps_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [zbps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [zbps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire zbps_pkg::in_item_t                   in_data,
  input  wire zbps_pkg::cmd_t                       cmd,
  output zbps_pkg::status_t                         st,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output zbps_pkg::out_item_t                       out_data
);
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LWA  = $clog2(MAX_WIDTH + 1);
  localparam int LHA  = $clog2(MAX_HEIGHT + 1);
  localparam int LW   = (LWA > 10) ? LWA : 10;
  localparam int LH   = (LHA > 10) ? LHA : 10;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);

  // Configuration registers.
  logic signed [31:0] origin_x, origin_y;
  logic [31:0]        inv_gsd;
  logic               inverse_mode;
  logic [9:0]         width_in_use, height_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_gsd       <= zbps_pkg::INV_GSD_RESET;
      inverse_mode  <= 1'b0;
      width_in_use  <= zbps_pkg::DIM_RESET;
      height_in_use <= zbps_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        zbps_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        zbps_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        zbps_pkg::REG_INV_GSD:       inv_gsd       <= cfg_data;
        zbps_pkg::REG_INVERSE_MODE:  inverse_mode  <= cfg_data[0];
        zbps_pkg::REG_WIDTH_IN_USE:  width_in_use  <= cfg_data[9:0];
        zbps_pkg::REG_HEIGHT_IN_USE: height_in_use <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lim_w;
  logic [LH-1:0] lim_h;
  assign lim_w = (LW'(width_in_use) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(width_in_use);
  assign lim_h = (LH'(height_in_use) > LH'(MAX_HEIGHT)) ? LH'(MAX_HEIGHT) : LH'(height_in_use);

  // Captured item.
  zbps_pkg::in_item_t item;
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
  end
  assign st.mode = item.mode;

  // Shared multiplier: magnitude of the 33-bit difference times inv_gsd.
  logic signed [32:0] diff;
  logic               diff_neg;
  logic [32:0]        mag;
  logic [63:0]        prod_next;
  logic [63:0]        prod;
  logic               prod_neg;

  assign diff = cmd.mul_y ? (33'(origin_y) - 33'(item.y)) : (33'(item.x) - 33'(origin_x));
  assign diff_neg = diff[32];
  assign mag = diff_neg ? 33'(-diff) : 33'(diff);
  assign prod_next = (64'(mag[31:0]) * 64'(inv_gsd)) + (mag[32] ? {inv_gsd, 32'd0} : 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod     <= prod_next;
      prod_neg <= diff_neg;
    end
  end

  // Round to nearest and range check of the product held in prod.
  // A small negative offset rounds to pixel zero, which exists only in a non-empty image.
  logic [64:0] rounded;
  logic [40:0] pix_v;
  logic        ok_w, ok_h;
  assign rounded = {1'b0, prod} + {1'b0, zbps_pkg::HALF_Q24};
  assign pix_v   = rounded[64:24];
  assign ok_w = prod_neg ? ((prod <= zbps_pkg::HALF_Q24) && (lim_w != '0))
                         : (pix_v < 41'(lim_w));
  assign ok_h = prod_neg ? ((prod <= zbps_pkg::HALF_Q24) && (lim_h != '0))
                         : (pix_v < 41'(lim_h));

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          ok_col, ok_row;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col    <= CW'(in_data.read_col);
      row    <= RW'(in_data.read_row);
      ok_col <= (LW'(in_data.read_col) < lim_w);
      ok_row <= (LH'(in_data.read_row) < lim_h);
    end else if (cmd.mul_y) begin
      // The x product is mapped while the y product is formed.
      col    <= prod_neg ? '0 : CW'(pix_v);
      ok_col <= ok_w;
    end else if (cmd.map_y) begin
      row    <= prod_neg ? '0 : RW'(pix_v);
      ok_row <= ok_h;
    end
  end

  logic [AW-1:0] addr;
  assign addr = AW'(AW'(row) * AW'(MAX_WIDTH)) + AW'(col);

  // Clearing pass over the valid map.
  logic [AW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step && clr_addr != LAST_ADDR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end
  assign st.clr_done = (clr_addr == LAST_ADDR);

  // Pixel stores.
  logic                         valid_rd;
  logic signed [DEPTH_BITS-1:0] depth_rd;
  logic [23:0]                  color_rd;
  logic signed [DEPTH_BITS-1:0] z_q;
  logic                         in_image, win, wr;

  assign z_q      = DEPTH_BITS'(item.z);
  assign in_image = ok_col && ok_row;
  assign win = in_image && (!valid_rd ||
               (inverse_mode ? (z_q > depth_rd) : (z_q < depth_rd)));
  assign wr  = cmd.finish && (item.mode == zbps_pkg::MODE_SPLAT) && win;

  zbps_ram #(.WIDTH(1), .DEPTH(NPIX)) u_valid (
    .clk(clk), .we(cmd.clr_step || wr), .waddr(cmd.clr_step ? clr_addr : addr),
    .wdata(!cmd.clr_step), .re(cmd.rd), .raddr(addr), .rdata(valid_rd)
  );
  zbps_ram #(.WIDTH(DEPTH_BITS), .DEPTH(NPIX)) u_depth (
    .clk(clk), .we(wr), .waddr(addr), .wdata(z_q),
    .re(cmd.rd), .raddr(addr), .rdata(depth_rd)
  );
  zbps_ram #(.WIDTH(24), .DEPTH(NPIX)) u_color (
    .clk(clk), .we(wr), .waddr(addr), .wdata({item.red, item.green, item.blue}),
    .re(cmd.rd), .raddr(addr), .rdata(color_rd)
  );

  // Result register.
  logic show;
  assign show = (item.mode == zbps_pkg::MODE_READ) && in_image && valid_rd;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.inside_res <= in_image;
      out_data.written    <= (item.mode == zbps_pkg::MODE_SPLAT) && win;
      out_data.pix_valid  <= show;
      out_data.pix_depth  <= show ? 24'(depth_rd) : '0;
      out_data.pix_red    <= show ? color_rd[23:16] : '0;
      out_data.pix_green  <= show ? color_rd[15:8] : '0;
      out_data.pix_blue   <= show ? color_rd[7:0] : '0;
    end
  end
endmodule
`default_nettype wire
